// File: hdl/sbwq_pkg.sv
// Package for the semaphore bank with wait queues: operation codes, field widths,
// stream packing widths and default sizes. No dependencies.
package sbwq_pkg;

  localparam int NUM_SEMS_DEF     = 32;
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int TASK_ID_BITS_DEF = 8;

  localparam int MODE_W  = 2;
  localparam int IDX_W   = 5;
  localparam int TASK_W  = 8;
  localparam int INIT_W  = 15;
  localparam int CNT_W   = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_POST   = 2'd2,
    MODE_UNLINK = 2'd3
  } mode_t;

endpackage

// File: hdl/sbwq_ram.sv
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
module sbwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/semaphore_bank_with_wait_queues.sv
// Top level of the semaphore bank: counts, slot flags and ring pointers in flops,
// waiting task ids in sbwq_ram. Depends on sbwq_pkg and sbwq_ram.
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser: mode; tdata: sem_index, task_id, init_value
// out_    | out | out_tvalid/tready  | tdata: blocked .. count_after
//
// One transfer in per cycle sustained while the output is not stalled; each result
// passes the input register, then the result register together with the queue RAM
// read. Reset empties all queues and frees all slots; the RAM is not
// cleared. A stalled output holds the whole pipeline, and in_tready drops only when
// both stages are full.
module semaphore_bank_with_wait_queues #(
  parameter int NUM_SEMS     = sbwq_pkg::NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH  = sbwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = sbwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [4:0] sem_index, [12:5] task_id, [27:13] init_value, [31:28] zero
  input  logic [sbwq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  logic [sbwq_pkg::MODE_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] blocked, [1] woken_valid, [9:2] woken_task, [10] queue_overflow,
  // [11] already_open, [27:12] count_after, [31:28] zero
  output logic [sbwq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RAM_D  = NUM_SEMS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);
  localparam int CNT_W  = sbwq_pkg::CNT_W;
  localparam logic [ADDR_W-1:0] QD_A       = ADDR_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  TAIL_RESET = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] q;
    q = {1'b0, p} + 1'b1;
    return (q >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : q[PTR_W-1:0];
  endfunction

  logic signed [CNT_W-1:0] cnt_r  [NUM_SEMS];
  logic                    used_r [NUM_SEMS];
  logic [PTR_W-1:0]        head_r [NUM_SEMS];
  logic [PTR_W-1:0]        tail_r [NUM_SEMS];

  logic                            s1_v_r;
  sbwq_pkg::mode_t                 s1_mode_r;
  logic [sbwq_pkg::IDX_W-1:0]      s1_idx_r;
  logic [sbwq_pkg::TASK_W-1:0]     s1_task_r;
  logic [sbwq_pkg::INIT_W-1:0]     s1_init_r;

  logic                    s2_v_r;
  logic                    s2_blocked_r;
  logic                    s2_wvalid_r;
  logic                    s2_ovf_r;
  logic                    s2_already_r;
  logic signed [CNT_W-1:0] s2_cnt_r;

  logic                    adv;
  logic [SEM_W-1:0]        sel;
  logic                    in_rng;
  logic signed [CNT_W-1:0] cur_cnt;
  logic [PTR_W-1:0]        cur_head;
  logic [PTR_W-1:0]        cur_tail;
  logic                    cur_used;
  logic signed [CNT_W-1:0] cnt_nxt;
  logic [PTR_W-1:0]        head_nxt;
  logic [PTR_W-1:0]        tail_nxt;
  logic                    used_nxt;
  logic                    blocked_nxt;
  logic                    wvalid_nxt;
  logic                    ovf_nxt;
  logic                    already_nxt;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [TASK_ID_BITS-1:0] ram_rdata;
  logic [TASK_ID_BITS-1:0] task_st;

  assign adv       = !s2_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;

  assign sel      = SEM_W'(s1_idx_r);
  assign in_rng   = (32'(s1_idx_r) < NUM_SEMS);
  assign cur_cnt  = cnt_r[sel];
  assign cur_head = head_r[sel];
  assign cur_tail = tail_r[sel];
  assign cur_used = used_r[sel];
  assign task_st  = TASK_ID_BITS'(s1_task_r);

  always_comb begin
    cnt_nxt     = cur_cnt;
    head_nxt    = cur_head;
    tail_nxt    = cur_tail;
    used_nxt    = cur_used;
    blocked_nxt = 1'b0;
    wvalid_nxt  = 1'b0;
    ovf_nxt     = 1'b0;
    already_nxt = 1'b0;
    ram_we      = 1'b0;
    case (s1_mode_r)
      sbwq_pkg::MODE_OPEN: begin
        if (cur_used) begin
          already_nxt = 1'b1;
        end else begin
          cnt_nxt  = signed'({1'b0, s1_init_r});
          used_nxt = 1'b1;
          head_nxt = '0;
          tail_nxt = TAIL_RESET;
        end
      end
      sbwq_pkg::MODE_WAIT: begin
        cnt_nxt = (cur_cnt == sbwq_pkg::CNT_MIN) ? cur_cnt : cur_cnt - 16'sd1;
        if (cnt_nxt < 0) begin
          blocked_nxt = 1'b1;
          if (cur_head == ring_next(ring_next(cur_tail))) begin
            ovf_nxt = 1'b1;
          end else begin
            tail_nxt = ring_next(cur_tail);
            ram_we   = 1'b1;
          end
        end
      end
      sbwq_pkg::MODE_POST: begin
        cnt_nxt = (cur_cnt == sbwq_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 16'sd1;
        if (cnt_nxt <= 0 && ring_next(cur_tail) != cur_head) begin
          wvalid_nxt = 1'b1;
          head_nxt   = ring_next(cur_head);
        end
      end
      sbwq_pkg::MODE_UNLINK: begin
        used_nxt = 1'b0;
        cnt_nxt  = '0;
      end
      default: begin
        cnt_nxt = cur_cnt;
      end
    endcase
  end

  assign ram_waddr = ADDR_W'(sel) * QD_A + ADDR_W'(tail_nxt);
  assign ram_raddr = ADDR_W'(sel) * QD_A + ADDR_W'(cur_head);

  sbwq_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (RAM_D)
  ) u_queue_ram (
    .clk   (clk),
    .we    (adv && s1_v_r && in_rng && ram_we),
    .waddr (ram_waddr),
    .wdata (task_st),
    .re    (adv),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        cnt_r[i]  <= '0;
        used_r[i] <= 1'b0;
        head_r[i] <= '0;
        tail_r[i] <= TAIL_RESET;
      end
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (adv) begin
        s2_v_r <= s1_v_r;
        if (s1_v_r && in_rng) begin
          cnt_r[sel]  <= cnt_nxt;
          used_r[sel] <= used_nxt;
          head_r[sel] <= head_nxt;
          tail_r[sel] <= tail_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= sbwq_pkg::mode_t'(in_tuser);
      s1_idx_r  <= in_tdata[4:0];
      s1_task_r <= in_tdata[12:5];
      s1_init_r <= in_tdata[27:13];
    end
    if (adv) begin
      s2_blocked_r <= in_rng && blocked_nxt;
      s2_wvalid_r  <= in_rng && wvalid_nxt;
      s2_ovf_r     <= in_rng && ovf_nxt;
      s2_already_r <= in_rng && already_nxt;
      s2_cnt_r     <= in_rng ? cnt_nxt : '0;
    end
  end

  assign out_tvalid = s2_v_r;
  assign out_tdata  = {4'b0, s2_cnt_r, s2_already_r, s2_ovf_r,
                       (s2_wvalid_r ? 8'(ram_rdata) : 8'd0), s2_wvalid_r, s2_blocked_r};

  a_woken_count: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_wvalid_r |-> s2_cnt_r <= 0)
    else $error("woken task reported with positive count");

  a_blocked_count: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_blocked_r |-> s2_cnt_r < 0)
    else $error("blocked caller with non-negative count");

  a_ovf_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_ovf_r |-> s2_blocked_r && !s2_wvalid_r && !s2_already_r)
    else $error("queue overflow without a blocking wait");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s2_v_r && !out_tready)
    else $error("input stalled while pipeline can advance");

endmodule

// File: tb/tb_semaphore_bank_with_wait_queues.sv
// Self-checking testbench for semaphore_bank_with_wait_queues: a stream driver and
// monitor with random gaps, checked against an in-bench semaphore and wait-queue model.
// Depends on sbwq_pkg and the RTL of the block.
module tb_semaphore_bank_with_wait_queues;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEM   = sbwq_pkg::NUM_SEMS_DEF;
  localparam int QDEPTH = sbwq_pkg::QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_ITEMS = 1700;

  typedef struct {
    sbwq_pkg::mode_t                 mode;
    logic [sbwq_pkg::IDX_W-1:0]      idx;
    logic [sbwq_pkg::TASK_W-1:0]     task_id;
    logic [sbwq_pkg::INIT_W-1:0]     init;
  } sem_op_t;

  typedef struct {
    logic                              blocked;
    logic                              woken_valid;
    logic [sbwq_pkg::TASK_W-1:0]       woken_task;
    logic                              overflow;
    logic                              already_open;
    logic signed [sbwq_pkg::CNT_W-1:0] count_after;
  } sem_result_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [sbwq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [sbwq_pkg::MODE_W-1:0]      in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sbwq_pkg::OUT_TDATA_W-1:0] out_tdata;

  sem_op_t     pending_ops[$];
  sem_result_t expected_results[$];

  logic signed [sbwq_pkg::CNT_W-1:0] sem_cnt[NSEM];
  logic                              sem_open[NSEM];
  int                                q_head[NSEM];
  int                                q_tail[NSEM];
  logic [sbwq_pkg::TASK_W-1:0]       waiters[NSEM][QDEPTH];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_blocked = 0;
  int n_woken = 0;
  int n_overflow = 0;
  int n_already = 0;
  int tx_gap = 0;
  int tx_burst = 0;
  int rx_stall = 0;
  int rx_burst = 0;
  int idle_cycles = 0;

  semaphore_bank_with_wait_queues i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int ring_adv(int p);
    return (p + 1 >= QDEPTH) ? 0 : p + 1;
  endfunction

  function automatic sem_result_t apply_sem_op(sem_op_t op);
    sem_result_t r;
    int s;
    r = '{default: '0};
    s = int'(op.idx);
    case (op.mode)
      sbwq_pkg::MODE_OPEN: begin
        if (sem_open[s]) begin
          r.already_open = 1'b1;
        end else begin
          sem_cnt[s]  = $signed({1'b0, op.init});
          sem_open[s] = 1'b1;
          q_head[s]   = 0;
          q_tail[s]   = QDEPTH - 1;
        end
      end
      sbwq_pkg::MODE_WAIT: begin
        if (sem_cnt[s] != sbwq_pkg::CNT_MIN) sem_cnt[s] = sem_cnt[s] - 16'sd1;
        if (sem_cnt[s] < 0) begin
          r.blocked = 1'b1;
          if (q_head[s] == ring_adv(ring_adv(q_tail[s]))) begin
            r.overflow = 1'b1;
          end else begin
            q_tail[s] = ring_adv(q_tail[s]);
            waiters[s][q_tail[s]] = op.task_id;
          end
        end
      end
      sbwq_pkg::MODE_POST: begin
        if (sem_cnt[s] != sbwq_pkg::CNT_MAX) sem_cnt[s] = sem_cnt[s] + 16'sd1;
        if (sem_cnt[s] <= 0 && ring_adv(q_tail[s]) != q_head[s]) begin
          r.woken_valid = 1'b1;
          r.woken_task  = waiters[s][q_head[s]];
          q_head[s]     = ring_adv(q_head[s]);
        end
      end
      default: begin
        sem_open[s] = 1'b0;
        sem_cnt[s]  = '0;
      end
    endcase
    r.count_after = sem_cnt[s];
    return r;
  endfunction

  function automatic int next_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic push_op(sbwq_pkg::mode_t mode, int idx, int task_id, int init);
    sem_op_t op;
    op.mode    = mode;
    op.idx     = idx[sbwq_pkg::IDX_W-1:0];
    op.task_id = task_id[sbwq_pkg::TASK_W-1:0];
    op.init    = init[sbwq_pkg::INIT_W-1:0];
    pending_ops.push_back(op);
    n_items++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: hold the item until the transfer, then advance or idle.
  always @(posedge clk) begin
    sem_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, op.init, op.task_id, op.idx};
        in_tuser  <= op.mode;
        tx_gap = next_gap(tx_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_stall = next_gap(rx_burst);
    end
  end

  // Monitor: check the result transfer, then predict from the input transfer.
  always @(posedge clk) begin
    sem_result_t want;
    sem_op_t     op;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          n_blocked  += want.blocked;
          n_woken    += want.woken_valid;
          n_overflow += want.overflow;
          n_already  += want.already_open;
          if (out_tdata[0] !== want.blocked)
            report_mismatch("blocked", out_tdata[0], want.blocked);
          if (out_tdata[1] !== want.woken_valid)
            report_mismatch("woken_valid", out_tdata[1], want.woken_valid);
          if (out_tdata[9:2] !== want.woken_task)
            report_mismatch("woken_task", out_tdata[9:2], want.woken_task);
          if (out_tdata[10] !== want.overflow)
            report_mismatch("queue_overflow", out_tdata[10], want.overflow);
          if (out_tdata[11] !== want.already_open)
            report_mismatch("already_open", out_tdata[11], want.already_open);
          if (out_tdata[27:12] !== want.count_after)
            report_mismatch("count_after", $signed(out_tdata[27:12]), want.count_after);
          if (out_tdata[31:28] !== 4'b0)
            report_mismatch("tdata pad", out_tdata[31:28], 0);
        end
      end
      if (in_tvalid && in_tready) begin
        op.mode    = sbwq_pkg::mode_t'(in_tuser);
        op.idx     = in_tdata[4:0];
        op.task_id = in_tdata[12:5];
        op.init    = in_tdata[27:13];
        expected_results.push_back(apply_sem_op(op));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int slot;
    int init;
    for (int s = 0; s < NSEM; s++) begin
      sem_cnt[s]  = '0;
      sem_open[s] = 1'b0;
      q_head[s]   = 0;
      q_tail[s]   = QDEPTH - 1;
      for (int e = 0; e < QDEPTH; e++) waiters[s][e] = '0;
    end

    push_op(sbwq_pkg::MODE_OPEN, 0, 0, 0);
    push_op(sbwq_pkg::MODE_OPEN, 0, 0, 5);
    push_op(sbwq_pkg::MODE_WAIT, 0, 8'hFF, 0);
    push_op(sbwq_pkg::MODE_WAIT, 0, 8'h00, 16'h7FFF);
    push_op(sbwq_pkg::MODE_POST, 0, 0, 0);
    push_op(sbwq_pkg::MODE_POST, 0, 0, 0);
    push_op(sbwq_pkg::MODE_POST, 0, 0, 0);
    push_op(sbwq_pkg::MODE_UNLINK, 0, 0, 0);
    push_op(sbwq_pkg::MODE_POST, 5, 3, 0);
    push_op(sbwq_pkg::MODE_WAIT, 5, 4, 0);
    push_op(sbwq_pkg::MODE_OPEN, 31, 0, 32767);
    push_op(sbwq_pkg::MODE_POST, 31, 0, 0);
    push_op(sbwq_pkg::MODE_WAIT, 31, 0, 0);
    push_op(sbwq_pkg::MODE_UNLINK, 31, 0, 0);
    push_op(sbwq_pkg::MODE_OPEN, 1, 0, 0);
    for (int k = 0; k < QDEPTH; k++) push_op(sbwq_pkg::MODE_WAIT, 1, 16 + k, 0);
    push_op(sbwq_pkg::MODE_OPEN, 1, 0, 9);
    push_op(sbwq_pkg::MODE_UNLINK, 1, 0, 0);
    push_op(sbwq_pkg::MODE_OPEN, 1, 0, 2);
    push_op(sbwq_pkg::MODE_POST, 1, 0, 0);

    while (n_items < N_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        slot = $urandom_range(0, NSEM - 1);
        init = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3);
        if ($urandom_range(0, 1))
          push_op(sbwq_pkg::MODE_UNLINK, slot, $urandom_range(0, 255), 0);
        push_op(sbwq_pkg::MODE_OPEN, slot, $urandom_range(0, 255), init);
        for (int k = $urandom_range(2, 20); k > 0; k--) begin
          if ($urandom_range(0, 29) == 0)
            push_op(sbwq_pkg::MODE_OPEN, slot, $urandom_range(0, 255),
                    $urandom_range(0, 32767));
          else
            push_op($urandom_range(0, 1) ? sbwq_pkg::MODE_WAIT : sbwq_pkg::MODE_POST, slot,
                    $urandom_range(0, 255), $urandom_range(0, 32767));
        end
      end else begin
        push_op(sbwq_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, NSEM - 1),
                $urandom_range(0, 255), $urandom_range(0, 32767));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_results < n_items) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d operations, %0d results checked: open, wait, post, unlink, upper bound.",
             n_items, n_results);
    $display("Saw %0d blocked waits, %0d wakeups, %0d queue overflows, %0d repeated opens.",
             n_blocked, n_woken, n_overflow, n_already);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
